// File: rtl/differential_qpsk_demodulator_defines.svh
// ----------------------------------------------------------------------------
// Differential QPSK demodulator - shared assertion macros
// Concurrent checks clocked on clock and quiet while reset is high.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_QPSK_DEMODULATOR_DEFINES_SVH
`define DIFFERENTIAL_QPSK_DEMODULATOR_DEFINES_SVH

// property must hold at every edge outside reset
`define DQPSK_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition must never be seen outside reset
`define DQPSK_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// File: rtl/dqpsk_pkg.sv
// ----------------------------------------------------------------------------
// dqpsk_pkg
// Widths, register codes, tables and the mu-law expander for the demodulator.
// ----------------------------------------------------------------------------
package dqpsk_pkg;

   localparam int ACCUM_WIDTH       = 40;
   localparam int CORDIC_STEPS      = 16;
   localparam int CARRIER_TABLE_LEN = 20;
   localparam int ATAN_LEN          = 20;

   localparam int SAMPLE_W    = 32;
   localparam int PCM_W       = 16;
   localparam int PROD_W      = 2 * PCM_W;
   localparam int ANGLE_W     = 16;
   localparam int DIBIT_W     = 2;
   localparam int CORDIC_W    = ACCUM_WIDTH + 3;
   localparam int STEP_W      = $clog2(ATAN_LEN);
   localparam int CARRIER_W   = $clog2(CARRIER_TABLE_LEN);
   localparam int THIRDS_W    = 6;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_START_SAMPLE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_END_SAMPLE   = 1'd1;

   localparam logic [SAMPLE_W-1:0] START_RESET  = '0;
   localparam logic [SAMPLE_W-1:0] END_RESET    = '1;
   localparam logic [SAMPLE_W-1:0] SAMPLE_LIMIT = '1;

   // carrier table walk: m advances by 3 mod 20, sine sits 15 entries on
   localparam logic [CARRIER_W-1:0] CARRIER_STEP = CARRIER_W'(3);
   localparam logic [CARRIER_W-1:0] CARRIER_WRAP = CARRIER_W'(CARRIER_TABLE_LEN - 3);
   localparam logic [CARRIER_W-1:0] SIN_OFFSET   = CARRIER_W'(15);
   localparam logic [CARRIER_W-1:0] SIN_WRAP     = CARRIER_W'(CARRIER_TABLE_LEN - 15);

   // symbol timing in thirds of a sample
   localparam logic [THIRDS_W-1:0] THIRDS_STEP       = THIRDS_W'(3);
   localparam logic [THIRDS_W-1:0] THIRDS_PER_SYMBOL = THIRDS_W'(40);

   localparam logic [ANGLE_W-1:0] HALF_TURN    = 16'h8000;
   localparam logic [ANGLE_W-1:0] EIGHTH_TURN  = 16'h2000;

   localparam logic [7:0] ULAW_BIAS = 8'h84;

   typedef struct packed {
      logic signed [ACCUM_WIDTH-1:0] acc_i;
      logic signed [ACCUM_WIDTH-1:0] acc_q;
      logic [SAMPLE_W-1:0]           sample_index;
   } symbol_type;

   function automatic logic signed [PCM_W-1:0] carrier_value(input logic [CARRIER_W-1:0] m);
      logic signed [PCM_W-1:0] v;
      case (m)
         5'd0:    v =  16'sd32767;
         5'd1:    v =  16'sd31163;
         5'd2:    v =  16'sd26509;
         5'd3:    v =  16'sd19260;
         5'd4:    v =  16'sd10126;
         5'd5:    v =  16'sd0;
         5'd6:    v = -16'sd10126;
         5'd7:    v = -16'sd19260;
         5'd8:    v = -16'sd26509;
         5'd9:    v = -16'sd31163;
         5'd10:   v = -16'sd32767;
         5'd11:   v = -16'sd31163;
         5'd12:   v = -16'sd26509;
         5'd13:   v = -16'sd19260;
         5'd14:   v = -16'sd10126;
         5'd15:   v =  16'sd0;
         5'd16:   v =  16'sd10126;
         5'd17:   v =  16'sd19260;
         5'd18:   v =  16'sd26509;
         5'd19:   v =  16'sd31163;
         default: v =  16'sd0;
      endcase
      return v;
   endfunction

   // round(atan(2^-i) * 32768 / pi)
   function automatic logic [ANGLE_W-1:0] atan_value(input logic [STEP_W-1:0] i);
      logic [ANGLE_W-1:0] v;
      case (i)
         5'd0:    v = 16'd8192;
         5'd1:    v = 16'd4836;
         5'd2:    v = 16'd2555;
         5'd3:    v = 16'd1297;
         5'd4:    v = 16'd651;
         5'd5:    v = 16'd326;
         5'd6:    v = 16'd163;
         5'd7:    v = 16'd81;
         5'd8:    v = 16'd41;
         5'd9:    v = 16'd20;
         5'd10:   v = 16'd10;
         5'd11:   v = 16'd5;
         5'd12:   v = 16'd3;
         5'd13:   v = 16'd1;
         5'd14:   v = 16'd1;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [PCM_W-1:0] ulaw_expand(input logic [7:0] b);
      logic [7:0]              u;
      logic [14:0]             t;
      logic signed [PCM_W-1:0] mag;
      logic signed [PCM_W-1:0] bias;
      u    = ~b;
      t    = 15'({u[3:0], 3'b000}) + 15'(ULAW_BIAS);
      t    = t << u[6:4];
      mag  = signed'({1'b0, t});
      bias = signed'(PCM_W'(ULAW_BIAS));
      return u[7] ? (bias - mag) : (mag - bias);
   endfunction

endpackage

// File: rtl/dqpsk_front.sv
// ----------------------------------------------------------------------------
// dqpsk_front
// Sample intake: mu-law expansion, carrier mixing, I/Q accumulation and
// symbol timing. Hands each finished symbol's accumulators to the queue.
// ----------------------------------------------------------------------------
module dqpsk_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_ulaw_byte,
   input  logic                                 csr_write,
   input  logic [dqpsk_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dqpsk_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                                 sym_valid,
   input  logic                                 sym_ready,
   output dqpsk_pkg::symbol_type                sym_data
);

   logic [dqpsk_pkg::SAMPLE_W-1:0]  start_ff, start_in;
   logic [dqpsk_pkg::SAMPLE_W-1:0]  end_ff, end_in;
   logic [dqpsk_pkg::SAMPLE_W-1:0]  sample_counter_ff, sample_counter_in;
   logic [dqpsk_pkg::CARRIER_W-1:0] carrier_ff, carrier_in;
   logic [dqpsk_pkg::CARRIER_W-1:0] sin_index;

   logic                                  p1_valid_ff, p1_valid_in;
   logic signed [dqpsk_pkg::PCM_W-1:0]    p1_pcm_ff, p1_pcm_in;
   logic signed [dqpsk_pkg::PCM_W-1:0]    p1_cos_ff, p1_cos_in;
   logic signed [dqpsk_pkg::PCM_W-1:0]    p1_sin_ff, p1_sin_in;
   logic [dqpsk_pkg::SAMPLE_W-1:0]        p1_index_ff, p1_index_in;

   logic                                  p2_valid_ff, p2_valid_in;
   logic signed [dqpsk_pkg::PROD_W-1:0]   p2_prod_i_ff, p2_prod_i_in;
   logic signed [dqpsk_pkg::PROD_W-1:0]   p2_prod_q_ff, p2_prod_q_in;
   logic [dqpsk_pkg::SAMPLE_W-1:0]        p2_index_ff, p2_index_in;

   logic [dqpsk_pkg::THIRDS_W-1:0]        thirds_ff, thirds_in;
   logic [dqpsk_pkg::THIRDS_W-1:0]        thirds_sum;
   logic signed [dqpsk_pkg::ACCUM_WIDTH-1:0] acc_i_ff, acc_i_in;
   logic signed [dqpsk_pkg::ACCUM_WIDTH-1:0] acc_q_ff, acc_q_in;
   logic signed [dqpsk_pkg::ACCUM_WIDTH-1:0] sum_i, sum_q;

   logic in_window;
   logic p2_close;
   logic p2_stall;
   logic p2_fire;
   logic req_fire;

   // -------------------------------------------------------------------------
   // window and carrier bookkeeping
   // -------------------------------------------------------------------------
   assign in_window = (sample_counter_ff >= start_ff) && (sample_counter_ff < end_ff);
   assign sin_index = (carrier_ff >= dqpsk_pkg::SIN_WRAP) ?
                      (carrier_ff - dqpsk_pkg::SIN_WRAP) : (carrier_ff + dqpsk_pkg::SIN_OFFSET);

   assign thirds_sum = thirds_ff + dqpsk_pkg::THIRDS_STEP;
   assign p2_close   = thirds_sum >= dqpsk_pkg::THIRDS_PER_SYMBOL;
   assign sum_i      = acc_i_ff + dqpsk_pkg::ACCUM_WIDTH'(p2_prod_i_ff);
   assign sum_q      = acc_q_ff + dqpsk_pkg::ACCUM_WIDTH'(p2_prod_q_ff);

   // only a symbol-closing sample can hold the pipe
   assign p2_stall  = p2_valid_ff & p2_close & ~sym_ready;
   assign p2_fire   = p2_valid_ff & ~p2_stall;
   assign req_stall = p1_valid_ff & p2_stall;
   assign req_fire  = req_valid & ~req_stall;

   assign sym_valid             = p2_valid_ff & p2_close;
   assign sym_data.acc_i        = sum_i;
   assign sym_data.acc_q        = sum_q;
   assign sym_data.sample_index = p2_index_ff;

   always_comb begin
      start_in = start_ff;
      end_in   = end_ff;
      if (csr_write) begin
         unique case (csr_index)
            dqpsk_pkg::REG_START_SAMPLE: start_in = csr_wdata;
            dqpsk_pkg::REG_END_SAMPLE:   end_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      sample_counter_in = sample_counter_ff;
      carrier_in        = carrier_ff;
      p1_valid_in       = p1_valid_ff;
      p1_pcm_in         = p1_pcm_ff;
      p1_cos_in         = p1_cos_ff;
      p1_sin_in         = p1_sin_ff;
      p1_index_in       = p1_index_ff;
      if (req_fire) begin
         if (sample_counter_ff != dqpsk_pkg::SAMPLE_LIMIT) begin
            sample_counter_in = sample_counter_ff + dqpsk_pkg::SAMPLE_W'(1);
         end
         carrier_in = (carrier_ff >= dqpsk_pkg::CARRIER_WRAP) ?
                      (carrier_ff - dqpsk_pkg::CARRIER_WRAP) :
                      (carrier_ff + dqpsk_pkg::CARRIER_STEP);
         // samples outside the window never enter the mixer
         p1_valid_in = in_window;
         p1_pcm_in   = dqpsk_pkg::ulaw_expand(req_ulaw_byte);
         p1_cos_in   = dqpsk_pkg::carrier_value(carrier_ff);
         p1_sin_in   = dqpsk_pkg::carrier_value(sin_index);
         p1_index_in = sample_counter_ff;
      end else if (!p2_stall) begin
         p1_valid_in = 1'b0;
      end
   end

   always_comb begin
      p2_valid_in  = p2_valid_ff;
      p2_prod_i_in = p2_prod_i_ff;
      p2_prod_q_in = p2_prod_q_ff;
      p2_index_in  = p2_index_ff;
      if (!p2_stall) begin
         p2_valid_in  = p1_valid_ff;
         p2_prod_i_in = p1_pcm_ff * p1_cos_ff;
         p2_prod_q_in = p1_pcm_ff * p1_sin_ff;
         p2_index_in  = p1_index_ff;
      end
   end

   always_comb begin
      thirds_in = thirds_ff;
      acc_i_in  = acc_i_ff;
      acc_q_in  = acc_q_ff;
      if (p2_fire) begin
         if (p2_close) begin
            thirds_in = thirds_sum - dqpsk_pkg::THIRDS_PER_SYMBOL;
            acc_i_in  = '0;
            acc_q_in  = '0;
         end else begin
            thirds_in = thirds_sum;
            acc_i_in  = sum_i;
            acc_q_in  = sum_q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff          <= dqpsk_pkg::START_RESET;
         end_ff            <= dqpsk_pkg::END_RESET;
         sample_counter_ff <= '0;
         carrier_ff        <= '0;
         p1_valid_ff       <= 1'b0;
         p2_valid_ff       <= 1'b0;
         thirds_ff         <= '0;
         acc_i_ff          <= '0;
         acc_q_ff          <= '0;
      end else begin
         start_ff          <= start_in;
         end_ff            <= end_in;
         sample_counter_ff <= sample_counter_in;
         carrier_ff        <= carrier_in;
         p1_valid_ff       <= p1_valid_in;
         p2_valid_ff       <= p2_valid_in;
         thirds_ff         <= thirds_in;
         acc_i_ff          <= acc_i_in;
         acc_q_ff          <= acc_q_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_pcm_ff    <= p1_pcm_in;
      p1_cos_ff    <= p1_cos_in;
      p1_sin_ff    <= p1_sin_in;
      p1_index_ff  <= p1_index_in;
      p2_prod_i_ff <= p2_prod_i_in;
      p2_prod_q_ff <= p2_prod_q_in;
      p2_index_ff  <= p2_index_in;
   end

endmodule

// File: rtl/dqpsk_queue.sv
// ----------------------------------------------------------------------------
// dqpsk_queue
// Short symbol queue between the sample front end and the CORDIC back end.
// ----------------------------------------------------------------------------
`include "differential_qpsk_demodulator_defines.svh"

module dqpsk_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  dqpsk_pkg::symbol_type  push_data,
   output logic                   pop_valid,
   input  logic                   pop,
   output dqpsk_pkg::symbol_type  pop_data
);

   dqpsk_pkg::symbol_type                entries_ff [dqpsk_pkg::QUEUE_DEPTH];
   logic [dqpsk_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [dqpsk_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [dqpsk_pkg::QUEUE_CNT_W-1:0]    count_ff, count_in;
   logic                                 push_fire;
   logic                                 pop_fire;

   assign push_ready = count_ff != dqpsk_pkg::QUEUE_CNT_W'(dqpsk_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push_fire  = push_valid & push_ready;
   assign pop_fire   = pop & pop_valid;
   assign pop_data   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == dqpsk_pkg::QUEUE_PTR_W'(dqpsk_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + dqpsk_pkg::QUEUE_PTR_W'(1);
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == dqpsk_pkg::QUEUE_PTR_W'(dqpsk_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + dqpsk_pkg::QUEUE_PTR_W'(1);
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + dqpsk_pkg::QUEUE_CNT_W'(1);
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - dqpsk_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   `DQPSK_ASSERT(a_count_range, count_ff <= dqpsk_pkg::QUEUE_CNT_W'(dqpsk_pkg::QUEUE_DEPTH), "queue count beyond depth")
   `DQPSK_ASSERT(a_push_only, (push_fire && !pop_fire && !reset) |=> (count_ff == $past(count_ff) + dqpsk_pkg::QUEUE_CNT_W'(1)), "push did not raise count")
   `DQPSK_ASSERT_NEVER(a_pop_empty, pop && !pop_valid, "pop from empty queue")

endmodule

// File: rtl/dqpsk_back.sv
// ----------------------------------------------------------------------------
// dqpsk_back
// Iterative vectoring CORDIC, differential phase against the previous
// symbol, and the registered result stage.
// ----------------------------------------------------------------------------
`include "differential_qpsk_demodulator_defines.svh"

module dqpsk_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                sym_valid,
   output logic                                sym_pop,
   input  dqpsk_pkg::symbol_type               sym_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [dqpsk_pkg::DIBIT_W-1:0]       rsp_dibit,
   output logic [dqpsk_pkg::SAMPLE_W-1:0]      rsp_symbol_number,
   output logic [dqpsk_pkg::SAMPLE_W-1:0]      rsp_sample_index,
   output logic signed [dqpsk_pkg::ANGLE_W-1:0] rsp_phase_step
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_ROTATE = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0] state_ff, state_in;

   logic signed [dqpsk_pkg::CORDIC_W-1:0] x_ff, x_in;
   logic signed [dqpsk_pkg::CORDIC_W-1:0] y_ff, y_in;
   logic signed [dqpsk_pkg::CORDIC_W-1:0] x_load, y_load;
   logic signed [dqpsk_pkg::CORDIC_W-1:0] dx, dy;
   logic [dqpsk_pkg::ANGLE_W-1:0]         z_ff, z_in;
   logic [dqpsk_pkg::STEP_W-1:0]          step_ff, step_in;
   logic                                  zero_ff, zero_in;
   logic [dqpsk_pkg::SAMPLE_W-1:0]        index_ff, index_in;

   logic [dqpsk_pkg::ANGLE_W-1:0]         ref_ff, ref_in;
   logic                                  ref_valid_ff, ref_valid_in;
   logic [dqpsk_pkg::SAMPLE_W-1:0]        symbol_count_ff, symbol_count_in;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [dqpsk_pkg::DIBIT_W-1:0]         rsp_dibit_ff, rsp_dibit_in;
   logic [dqpsk_pkg::SAMPLE_W-1:0]        rsp_number_ff, rsp_number_in;
   logic [dqpsk_pkg::SAMPLE_W-1:0]        rsp_index_ff, rsp_index_in;
   logic [dqpsk_pkg::ANGLE_W-1:0]         rsp_phase_ff, rsp_phase_in;

   logic [dqpsk_pkg::ANGLE_W-1:0]         angle;
   logic [dqpsk_pkg::ANGLE_W-1:0]         delta;
   logic [dqpsk_pkg::ANGLE_W-1:0]         delta_rounded;
   logic                                  out_free;
   logic                                  load_rsp;

   assign x_load        = dqpsk_pkg::CORDIC_W'(sym_data.acc_i);
   assign y_load        = dqpsk_pkg::CORDIC_W'(sym_data.acc_q);
   assign dx            = y_ff >>> step_ff;
   assign dy            = x_ff >>> step_ff;
   assign angle         = zero_ff ? '0 : z_ff;
   assign delta         = angle - ref_ff;
   assign delta_rounded = delta + dqpsk_pkg::EIGHTH_TURN;
   assign out_free      = ~rsp_valid_ff | ~rsp_stall;
   assign load_rsp      = (state_ff == ST_FINISH) & ref_valid_ff & out_free;
   assign sym_pop       = (state_ff == ST_IDLE) & sym_valid;

   always_comb begin
      state_in        = state_ff;
      x_in            = x_ff;
      y_in            = y_ff;
      z_in            = z_ff;
      step_in         = step_ff;
      zero_in         = zero_ff;
      index_in        = index_ff;
      ref_in          = ref_ff;
      ref_valid_in    = ref_valid_ff;
      symbol_count_in = symbol_count_ff;
      rsp_dibit_in    = rsp_dibit_ff;
      rsp_number_in   = rsp_number_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_phase_in    = rsp_phase_ff;
      rsp_valid_in    = rsp_valid_ff & rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (sym_valid) begin
               zero_in  = (sym_data.acc_i == '0) && (sym_data.acc_q == '0);
               index_in = sym_data.sample_index;
               step_in  = '0;
               // fold the left half-plane over before the micro-rotations
               if (sym_data.acc_i < 0) begin
                  x_in = -x_load;
                  y_in = -y_load;
                  z_in = dqpsk_pkg::HALF_TURN;
               end else begin
                  x_in = x_load;
                  y_in = y_load;
                  z_in = '0;
               end
               state_in = ST_ROTATE;
            end
         end
         ST_ROTATE: begin
            if (y_ff < 0) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - dqpsk_pkg::atan_value(step_ff);
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + dqpsk_pkg::atan_value(step_ff);
            end
            if (step_ff == dqpsk_pkg::STEP_W'(dqpsk_pkg::CORDIC_STEPS - 1)) begin
               state_in = ST_FINISH;
            end else begin
               step_in = step_ff + dqpsk_pkg::STEP_W'(1);
            end
         end
         ST_FINISH: begin
            if (!ref_valid_ff) begin
               // first symbol only sets the reference
               ref_valid_in = 1'b1;
               ref_in       = angle;
               state_in     = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_dibit_in    = delta_rounded[dqpsk_pkg::ANGLE_W-1 -: dqpsk_pkg::DIBIT_W];
               rsp_number_in   = symbol_count_ff;
               rsp_index_in    = index_ff;
               rsp_phase_in    = delta;
               symbol_count_in = symbol_count_ff + dqpsk_pkg::SAMPLE_W'(1);
               ref_in          = angle;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         ref_ff          <= '0;
         ref_valid_ff    <= 1'b0;
         symbol_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         ref_ff          <= ref_in;
         ref_valid_ff    <= ref_valid_in;
         symbol_count_ff <= symbol_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      y_ff          <= y_in;
      z_ff          <= z_in;
      step_ff       <= step_in;
      zero_ff       <= zero_in;
      index_ff      <= index_in;
      rsp_dibit_ff  <= rsp_dibit_in;
      rsp_number_ff <= rsp_number_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_phase_ff  <= rsp_phase_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_dibit         = rsp_dibit_ff;
   assign rsp_symbol_number = rsp_number_ff;
   assign rsp_sample_index  = rsp_index_ff;
   assign rsp_phase_step    = signed'(rsp_phase_ff);

   `DQPSK_ASSERT(a_step_range, (state_ff == ST_ROTATE) |-> (step_ff <= dqpsk_pkg::STEP_W'(dqpsk_pkg::CORDIC_STEPS - 1)), "CORDIC step beyond last")
   `DQPSK_ASSERT(a_load_shows, (load_rsp && !reset) |=> rsp_valid_ff, "loaded result not presented")
   `DQPSK_ASSERT(a_count_step, (load_rsp && !reset) |=> (symbol_count_ff == $past(symbol_count_ff) + dqpsk_pkg::SAMPLE_W'(1)), "symbol count did not advance")

endmodule

// File: rtl/differential_qpsk_demodulator.sv
// ----------------------------------------------------------------------------
// differential_qpsk_demodulator
// V.22-style DQPSK receiver: mu-law samples in, dibits out, one per symbol after the first.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one mu-law byte per transaction (req_valid / req_stall).
//   rsp_*  : one result per symbol after the first: dibit, running symbol
//            number, closing sample index and signed phase step.
//   csr_*  : write-only start_sample / end_sample, written while idle.
// Path    : closing sample -> symbol queue -> CORDIC -> output register.
// Throughput: one sample per cycle into the two-stage mixer while req_stall is
//   low. Each symbol occupies the iterative CORDIC from idle to finish, and no
//   new symbol is popped before it is done; with symbols 13 to 14 samples apart
//   the two-entry symbol queue fills.
// Reset   : synchronous; clears window to all samples, timing, accumulators,
//   sample count, symbol count and the phase reference.
// Stall   : a waiting result sits in the output register; the CORDIC keeps
//   going on the next symbol and holds only when a new result is ready,
//   after which the queue and then req_stall push back.
// ----------------------------------------------------------------------------
module differential_qpsk_demodulator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [7:0]                            req_ulaw_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [dqpsk_pkg::DIBIT_W-1:0]         rsp_dibit,
   output logic [dqpsk_pkg::SAMPLE_W-1:0]        rsp_symbol_number,
   output logic [dqpsk_pkg::SAMPLE_W-1:0]        rsp_sample_index,
   output logic signed [dqpsk_pkg::ANGLE_W-1:0]  rsp_phase_step,
   input  logic                                  csr_write,
   input  logic [dqpsk_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [dqpsk_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic                  push_valid;
   logic                  push_ready;
   dqpsk_pkg::symbol_type push_data;
   logic                  pop_valid;
   logic                  pop;
   dqpsk_pkg::symbol_type pop_data;

   dqpsk_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_ulaw_byte (req_ulaw_byte),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .sym_valid     (push_valid),
      .sym_ready     (push_ready),
      .sym_data      (push_data)
   );

   dqpsk_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_data   (pop_data)
   );

   dqpsk_back u_back (
      .clock             (clock),
      .reset             (reset),
      .sym_valid         (pop_valid),
      .sym_pop           (pop),
      .sym_data          (pop_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_dibit         (rsp_dibit),
      .rsp_symbol_number (rsp_symbol_number),
      .rsp_sample_index  (rsp_sample_index),
      .rsp_phase_step    (rsp_phase_step)
   );

endmodule
